// ----- hdl/stereo_pingpong_delay_defines.svh -----
// Assertion macros shared by the stereo delay RTL.
`ifndef STEREO_PINGPONG_DELAY_DEFINES_SVH
`define STEREO_PINGPONG_DELAY_DEFINES_SVH

// same-cycle implication
`define SPD_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("stereo_pingpong_delay: assertion failed");

// next-cycle implication
`define SPD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("stereo_pingpong_delay: assertion failed");

`endif

// ----- hdl/spd_pkg.sv -----
// Shared types and constants of the stereo delay.
package spd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int DELAY_W = 16;
  localparam int GAIN_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W = 42;
  localparam int LINE_DEPTH_DEF = 65536;

  localparam logic [GAIN_W:0] UNITY = 17'd32768;
  localparam int ROUND_HALF = 16384;
  localparam int SMAX = 8388607;
  localparam int SMIN = -8388608;

  localparam logic [DELAY_W-1:0] DELAY_RST = 16'd1;
  localparam logic [GAIN_W-1:0] MIX_RST = 16'd4915;
  localparam logic [GAIN_W-1:0] FB_RST = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LEFT    = 3'd0,
    REG_DELAY_RIGHT   = 3'd1,
    REG_SYNC_ENABLE   = 3'd2,
    REG_MIX_GAIN      = 3'd3,
    REG_FEEDBACK_GAIN = 3'd4,
    REG_DELAY_MODE    = 3'd5,
    REG_PINGPONG_MODE = 3'd6
  } reg_index_t;

  typedef enum logic {
    MODE_STRAIGHT = 1'b0,
    MODE_CROSS    = 1'b1
  } delay_mode_t;

  typedef enum logic [1:0] {
    PP_CENTER = 2'd0,
    PP_LEFT   = 2'd1,
    PP_RIGHT  = 2'd2
  } pingpong_t;

  // gains already clamped to unity
  typedef struct packed {
    logic [GAIN_W:0] mix;
    logic [GAIN_W:0] mix_inv;
    logic [GAIN_W:0] fb;
    logic            pingpong;
    logic            inject_l;
    logic            inject_r;
  } spd_ctrl_t;

endpackage

// ----- hdl/spd_in_if.sv -----
// Input channel: one stereo sample pair per item.
interface spd_in_if;
  logic valid;
  logic ready;
  logic signed [spd_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [spd_pkg::SAMPLE_W-1:0] right_sample;

  modport source(output valid, output left_sample, output right_sample, input ready);
  modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- hdl/spd_out_if.sv -----
// Output channel: one mixed stereo pair per item.
interface spd_out_if;
  logic valid;
  logic ready;
  logic signed [spd_pkg::SAMPLE_W-1:0] left_result;
  logic signed [spd_pkg::SAMPLE_W-1:0] right_result;

  modport source(output valid, output left_result, output right_result, input ready);
  modport sink(input valid, input left_result, input right_result, output ready);
endinterface

// ----- hdl/spd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module spd_ram #(
  parameter int WIDTH = spd_pkg::SAMPLE_W,
  parameter int DEPTH = spd_pkg::LINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/spd_addr.sv -----
// Write pointer, fill tracking and delayed read addresses.
module spd_addr #(
  parameter int LINE_DEPTH = spd_pkg::LINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [spd_pkg::DELAY_W-1:0]         delay_l,
  input  logic [spd_pkg::DELAY_W-1:0]         delay_r,
  output logic [$clog2(LINE_DEPTH)-1:0]       wr_pos,
  output logic [$clog2(LINE_DEPTH)-1:0]       rd_addr_l,
  output logic [$clog2(LINE_DEPTH)-1:0]       rd_addr_r,
  output logic                                rd_vld_l,
  output logic                                rd_vld_r
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = (AW > spd_pkg::DELAY_W) ? AW : spd_pkg::DELAY_W;

  logic [AW-1:0] pos;
  logic          wrapped;
  logic [AW-1:0] dc_l, dc_r;
  logic [AW:0]   diff_l, diff_r;

  function automatic logic [AW-1:0] clamp_delay(input logic [spd_pkg::DELAY_W-1:0] d);
    logic [CW-1:0] w;
    w = CW'(d);
    if (w == '0) begin
      clamp_delay = AW'(1);
    end else if (w > CW'(LINE_DEPTH - 1)) begin
      clamp_delay = AW'(LINE_DEPTH - 1);
    end else begin
      clamp_delay = w[AW-1:0];
    end
  endfunction

  always_comb begin
    dc_l   = clamp_delay(delay_l);
    dc_r   = clamp_delay(delay_r);
    diff_l = {1'b0, pos} - {1'b0, dc_l};
    diff_r = {1'b0, pos} - {1'b0, dc_r};
    // borrow means the tap sits behind slot zero: wrap by the line depth
    rd_addr_l = diff_l[AW] ? AW'(diff_l + (AW+1)'(LINE_DEPTH)) : diff_l[AW-1:0];
    rd_addr_r = diff_r[AW] ? AW'(diff_r + (AW+1)'(LINE_DEPTH)) : diff_r[AW-1:0];
    // slots below pos are written; all of them once the pointer has wrapped
    rd_vld_l = wrapped || !diff_l[AW];
    rd_vld_r = wrapped || !diff_r[AW];
  end

  assign wr_pos = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      wrapped <= 1'b0;
    end else if (advance) begin
      if (pos == AW'(LINE_DEPTH - 1)) begin
        pos     <= '0;
        wrapped <= 1'b1;
      end else begin
        pos <= pos + AW'(1);
      end
    end
  end

endmodule

// ----- hdl/spd_arith.sv -----
// Gain products, dry/wet mix and feedback sums with rounding and saturation.
module spd_arith (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic signed [spd_pkg::SAMPLE_W-1:0]   x_l,
  input  logic signed [spd_pkg::SAMPLE_W-1:0]   x_r,
  input  logic signed [spd_pkg::SAMPLE_W-1:0]   wet_l,
  input  logic signed [spd_pkg::SAMPLE_W-1:0]   wet_r,
  input  spd_pkg::spd_ctrl_t                    ctrl,
  output logic signed [spd_pkg::SAMPLE_W-1:0]   res_l,
  output logic signed [spd_pkg::SAMPLE_W-1:0]   res_r,
  output logic signed [spd_pkg::SAMPLE_W-1:0]   wnew_l,
  output logic signed [spd_pkg::SAMPLE_W-1:0]   wnew_r
);

  localparam int SW = spd_pkg::SAMPLE_W;
  localparam int AW = spd_pkg::ACC_W;
  localparam int RW = AW - 15;
  localparam logic signed [RW-1:0] R_MAX = RW'(spd_pkg::SMAX);
  localparam logic signed [RW-1:0] R_MIN = RW'(spd_pkg::SMIN);

  logic signed [AW-1:0] dry_l_c, dry_r_c, mixw_l_c, mixw_r_c, fb_l_c, fb_r_c;
  logic signed [AW-1:0] dry_l, dry_r, mixw_l, mixw_r, fb_l, fb_r;
  logic signed [SW-1:0] xs_l, xs_r;
  logic signed [SW:0]   sum_x;
  logic signed [AW-1:0] mono, direct_l, direct_r, acc_l, acc_r;

  function automatic logic signed [SW-1:0] round_sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    logic signed [RW-1:0] r;
    t = v + AW'(spd_pkg::ROUND_HALF);
    r = t[AW-1:15];
    if (r > R_MAX) begin
      round_sat = R_MAX[SW-1:0];
    end else if (r < R_MIN) begin
      round_sat = R_MIN[SW-1:0];
    end else begin
      round_sat = r[SW-1:0];
    end
  endfunction

  // multiply stage
  always_comb begin
    dry_l_c  = x_l * $signed({1'b0, ctrl.mix_inv});
    dry_r_c  = x_r * $signed({1'b0, ctrl.mix_inv});
    mixw_l_c = wet_l * $signed({1'b0, ctrl.mix});
    mixw_r_c = wet_r * $signed({1'b0, ctrl.mix});
    fb_l_c   = wet_l * $signed({1'b0, ctrl.fb});
    fb_r_c   = wet_r * $signed({1'b0, ctrl.fb});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dry_l  <= dry_l_c;
      dry_r  <= dry_r_c;
      mixw_l <= mixw_l_c;
      mixw_r <= mixw_r_c;
      fb_l   <= fb_l_c;
      fb_r   <= fb_r_c;
      xs_l   <= x_l;
      xs_r   <= x_r;
    end
  end

  // sum, round and saturate stage
  always_comb begin
    sum_x    = xs_l + xs_r;
    mono     = {{(AW-SW-15){sum_x[SW]}}, sum_x, 14'b0};
    direct_l = {{(AW-SW-15){xs_l[SW-1]}}, xs_l, 15'b0};
    direct_r = {{(AW-SW-15){xs_r[SW-1]}}, xs_r, 15'b0};
    if (ctrl.pingpong) begin
      acc_l = fb_r + (ctrl.inject_l ? mono : '0);
      acc_r = fb_l + (ctrl.inject_r ? mono : '0);
    end else begin
      acc_l = direct_l + fb_l;
      acc_r = direct_r + fb_r;
    end
    res_l  = round_sat(dry_l + mixw_l);
    res_r  = round_sat(dry_r + mixw_r);
    wnew_l = round_sat(acc_l);
    wnew_r = round_sat(acc_r);
  end

endmodule

// ----- hdl/stereo_pingpong_delay.sv -----
// Top level of the stereo feedback delay with ping-pong cross feedback.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        left_sample, right_sample (s24)
//   out_ch    out   valid/ready        left_result, right_result (s24)
//   cfg       in    cfg_we, no wait    cfg_index, cfg_data
//
// Memory read at accept, products next cycle, then sum/round with the memory
// write-back. The write-back of one item feeds the read of the next (delay of
// one), so a new item is accepted only with or after the last one's write-back.
// Reset clears control only; never-written slots read as zero via fill tracking.
// Output register holds a result while the next item is read and multiplied.
`include "stereo_pingpong_delay_defines.svh"

module stereo_pingpong_delay #(
  parameter int LINE_DEPTH = spd_pkg::LINE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  spd_in_if.sink                          in_ch,
  spd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int SW = spd_pkg::SAMPLE_W;

  // configuration
  logic [spd_pkg::DELAY_W-1:0] delay_left, delay_right;
  logic                        sync_enable;
  logic [spd_pkg::GAIN_W-1:0]  mix_gain, feedback_gain;
  logic                        delay_mode;
  logic [1:0]                  pingpong_mode;
  spd_pkg::spd_ctrl_t          ctrl;

  // pipeline control
  logic s1_valid, s2_valid, out_valid;
  logic in_fire, out_free, mem_we;

  // addressing
  logic [AW-1:0] wr_pos, rd_addr_l, rd_addr_r, wr_addr;
  logic          rd_vld_l, rd_vld_r;
  logic          vld_l, vld_r, hit_l, hit_r;

  // payload
  logic signed [SW-1:0] x_l, x_r, fwd_l, fwd_r;
  logic [SW-1:0]        ram_l, ram_r;
  logic signed [SW-1:0] wet_l, wet_r;
  logic signed [SW-1:0] res_l, res_r, wnew_l, wnew_r;
  logic signed [SW-1:0] out_l, out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_left    <= spd_pkg::DELAY_RST;
      delay_right   <= spd_pkg::DELAY_RST;
      sync_enable   <= 1'b0;
      mix_gain      <= spd_pkg::MIX_RST;
      feedback_gain <= spd_pkg::FB_RST;
      delay_mode    <= spd_pkg::MODE_STRAIGHT;
      pingpong_mode <= spd_pkg::PP_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spd_pkg::REG_DELAY_LEFT:    delay_left    <= cfg_data;
        spd_pkg::REG_DELAY_RIGHT:   delay_right   <= cfg_data;
        spd_pkg::REG_SYNC_ENABLE:   sync_enable   <= cfg_data[0];
        spd_pkg::REG_MIX_GAIN:      mix_gain      <= cfg_data;
        spd_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        spd_pkg::REG_DELAY_MODE:    delay_mode    <= cfg_data[0];
        spd_pkg::REG_PINGPONG_MODE: pingpong_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.mix      = ({1'b0, mix_gain} > spd_pkg::UNITY) ? spd_pkg::UNITY : {1'b0, mix_gain};
    ctrl.mix_inv  = spd_pkg::UNITY - ctrl.mix;
    ctrl.fb       = ({1'b0, feedback_gain} > spd_pkg::UNITY) ? spd_pkg::UNITY
                                                             : {1'b0, feedback_gain};
    ctrl.pingpong = (delay_mode == spd_pkg::MODE_CROSS);
    case (pingpong_mode)
      spd_pkg::PP_CENTER: begin
        ctrl.inject_l = 1'b1;
        ctrl.inject_r = 1'b1;
      end
      spd_pkg::PP_LEFT: begin
        ctrl.inject_l = 1'b1;
        ctrl.inject_r = 1'b0;
      end
      default: begin
        // right, and the unused code
        ctrl.inject_l = 1'b0;
        ctrl.inject_r = 1'b1;
      end
    endcase
  end

  // handshake
  assign out_free     = !out_valid || out_ch.ready;
  assign mem_we       = s2_valid && out_free;
  assign in_ch.ready  = !s1_valid && (!s2_valid || out_free);
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      if (s1_valid) begin
        s2_valid <= 1'b1;
      end else if (mem_we) begin
        s2_valid <= 1'b0;
      end
      if (mem_we) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  spd_addr #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_addr (
    .clk      (clk),
    .rst      (rst),
    .advance  (in_fire),
    .delay_l  (delay_left),
    .delay_r  (sync_enable ? delay_left : delay_right),
    .wr_pos   (wr_pos),
    .rd_addr_l(rd_addr_l),
    .rd_addr_r(rd_addr_r),
    .rd_vld_l (rd_vld_l),
    .rd_vld_r (rd_vld_r)
  );

  // capture at accept; a write-back on the same edge to the tap is forwarded
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_l     <= in_ch.left_sample;
      x_r     <= in_ch.right_sample;
      wr_addr <= wr_pos;
      vld_l   <= rd_vld_l;
      vld_r   <= rd_vld_r;
      hit_l   <= mem_we && (rd_addr_l == wr_addr);
      hit_r   <= mem_we && (rd_addr_r == wr_addr);
      fwd_l   <= wnew_l;
      fwd_r   <= wnew_r;
    end
  end

  spd_ram #(
    .WIDTH(SW),
    .DEPTH(LINE_DEPTH)
  ) u_left_line (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wr_addr),
    .wdata(wnew_l),
    .re   (in_fire),
    .raddr(rd_addr_l),
    .rdata(ram_l)
  );

  spd_ram #(
    .WIDTH(SW),
    .DEPTH(LINE_DEPTH)
  ) u_right_line (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wr_addr),
    .wdata(wnew_r),
    .re   (in_fire),
    .raddr(rd_addr_r),
    .rdata(ram_r)
  );

  assign wet_l = hit_l ? fwd_l : (vld_l ? $signed(ram_l) : '0);
  assign wet_r = hit_r ? fwd_r : (vld_r ? $signed(ram_r) : '0);

  spd_arith u_arith (
    .clk   (clk),
    .load  (s1_valid),
    .x_l   (x_l),
    .x_r   (x_r),
    .wet_l (wet_l),
    .wet_r (wet_r),
    .ctrl  (ctrl),
    .res_l (res_l),
    .res_r (res_r),
    .wnew_l(wnew_l),
    .wnew_r(wnew_r)
  );

  // output register
  always_ff @(posedge clk) begin
    if (mem_we) begin
      out_l <= res_l;
      out_r <= res_r;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.left_result  = out_l;
  assign out_ch.right_result = out_r;

  `SPD_ASSERT_NEXT(a_spacing, clk, rst, in_fire, !in_ch.ready)
  `SPD_ASSERT_NEXT(a_pipe_adv, clk, rst, s1_valid, s2_valid)
  `SPD_ASSERT_NEXT(a_wb_result, clk, rst, mem_we, out_ch.valid)
  `SPD_ASSERT_NEXT(a_stall_hold, clk, rst, s2_valid && !out_free, s2_valid && $stable(wr_addr))

endmodule
